### hdl/smoothed_variable_delay_line_core_assert.svh
// Assertion macros for the smoothed variable delay line core.
`ifndef SMOOTHED_VARIABLE_DELAY_LINE_CORE_ASSERT_SVH
`define SMOOTHED_VARIABLE_DELAY_LINE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

`define SVDL_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SVDL_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SVDL_ASSERT_IMPL(name, ante, cons, msg)

`define SVDL_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

### hdl/svdl_pkg.sv
// Shared constants for the smoothed variable delay line core.
package svdl_pkg;

    localparam int DEPTH_LOG2_DEF  = 17;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int SAMPLE_W    = 16;
    localparam int REQ_W       = 17;
    localparam int COEF_W      = 17;
    localparam int FRAC_BITS   = 16;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;

    localparam logic [COEF_W-1:0] COEF_ONE   = 17'd65536;
    localparam logic [COEF_W-1:0] COEF_RESET = 17'd655;

    localparam int RESET_DELAY = 10000;
    localparam int ROUND_HALF  = 32768;

    localparam int OFIFO_ADDR_W = 2;
    localparam int OFIFO_DEPTH  = 1 << OFIFO_ADDR_W;

endpackage

### hdl/svdl_store.sv
// Sample store: one write port and one registered read port.
module svdl_store
    import svdl_pkg::*;
#(
    parameter int ADDR_W = DEPTH_LOG2_DEF,
    parameter int DATA_W = SAMPLE_BITS_DEF
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [1 << ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    // Read returns the old contents when both ports hit the same entry.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/svdl_ofifo.sv
// Small output queue that decouples the pipeline from the result receiver.
module svdl_ofifo
    import svdl_pkg::*;
#(
    parameter int DATA_W = OUT_TDATA_W,
    parameter int ADDR_W = OFIFO_ADDR_W
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data,
    output logic [ADDR_W:0]   count
);

    logic [DATA_W-1:0] slot_reg [1 << ADDR_W];
    logic [ADDR_W-1:0] head_reg;
    logic [ADDR_W-1:0] head_next;
    logic [ADDR_W-1:0] tail_reg;
    logic [ADDR_W-1:0] tail_next;
    logic [ADDR_W:0]   count_reg;
    logic [ADDR_W:0]   count_next;
    logic              pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid & out_ready;
    assign out_data  = slot_reg[head_reg];
    assign count     = count_reg;

    always_comb
    begin
        head_next  = pop  ? head_reg + 1'b1 : head_reg;
        tail_next  = push ? tail_reg + 1'b1 : tail_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail_reg] <= push_data;
        end
    end

endmodule

### hdl/smoothed_variable_delay_line_core.sv
// Smoothed variable delay line: a sample store read at a slowly gliding delay.
// Input requests arrive on s_tvalid/s_tready/s_tdata, each with one sample and
// a requested delay in samples; the request is saturated to DEPTH-1. Every
// request yields exactly one delayed sample on m_tvalid/m_tready/m_tdata.
// The delay used for reading glides toward the request by a one-pole step
// whose size is set by smooth_coef (Q1.16, 65536 or more jumps at once). The
// user must have it written through cfg_wen/cfg_wdata only while the block is
// idle; the block itself does not enforce this. Throughput is one request per
// clock cycle while s_tready is high; the combinational multiply-add on the
// smoothed delay and the one write plus one read per cycle on the store set it.
// Up to m_tvalid, a request goes through delay update, store access and queue.
// Reset clears the write pointer, sets the delay to 10000 samples (or DEPTH-1
// when the store is smaller) and the coefficient to 655. The store itself is
// not cleared: entries that were never written since reset are recognized from
// the write pointer and a wrap flag and read as zero, so no clearing pass runs
// and requests are taken right after reset.
// When the receiver stalls, results collect in a four-entry queue; s_tready
// drops once the queue plus the requests still in the pipeline would fill it.
`include "smoothed_variable_delay_line_core_assert.svh"

module smoothed_variable_delay_line_core
    import svdl_pkg::*;
#(
    parameter int DEPTH_LOG2  = DEPTH_LOG2_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration: smooth_coef in bits 16:0.
    input  logic                   cfg_wen,
    input  logic [COEF_W-1:0]      cfg_wdata,
    // Fields from bit 0: sample_in [15:0], delay_request [32:16], zero padding.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // Fields from bit 0: sample_out [15:0].
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int DEPTH  = 1 << DEPTH_LOG2;
    localparam int SD_W   = DEPTH_LOG2 + FRAC_BITS;
    localparam int PW     = SD_W + 1 + COEF_W;
    localparam int CMP_W  = (DEPTH_LOG2 > REQ_W) ? DEPTH_LOG2 : REQ_W;
    localparam int RST_INT = (RESET_DELAY > DEPTH - 1) ? DEPTH - 1 : RESET_DELAY;

    localparam logic [DEPTH_LOG2-1:0] WP_LAST = DEPTH_LOG2'(DEPTH - 1);
    localparam logic [SD_W-1:0] SD_RESET =
        {DEPTH_LOG2'(RST_INT), {FRAC_BITS{1'b0}}};

    // ------------------------------------------------------------------
    // Stage A: accept the request and advance the smoothed delay.
    // ------------------------------------------------------------------
    logic                    s_fire;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [REQ_W-1:0]        delay_request;
    logic signed [31:0]      sample_ext;
    logic [CMP_W-1:0]        req_ext;
    logic [CMP_W-1:0]        req_max;
    logic [DEPTH_LOG2-1:0]   target_int;
    logic [SD_W-1:0]         target;
    logic signed [SD_W:0]    diff;
    logic                    coef_full;
    logic signed [PW-1:0]    prod;
    logic signed [PW-1:0]    rounded;
    logic signed [SD_W+1:0]  step;
    logic signed [SD_W+1:0]  sum;

    logic [COEF_W-1:0]       smooth_coef_reg;
    logic [SD_W-1:0]         smoothed_reg;
    logic [SD_W-1:0]         smoothed_next;
    logic [DEPTH_LOG2-1:0]   wp_reg;
    logic                    wrapped_reg;

    assign s_fire        = s_tvalid & s_tready;
    assign sample_in     = s_tdata[SAMPLE_W-1:0];
    assign delay_request = s_tdata[SAMPLE_W+REQ_W-1:SAMPLE_W];
    assign sample_ext    = 32'(sample_in);

    always_comb
    begin
        req_ext    = CMP_W'(delay_request);
        req_max    = CMP_W'(DEPTH - 1);
        target_int = (req_ext > req_max) ? req_max[DEPTH_LOG2-1:0]
                                         : req_ext[DEPTH_LOG2-1:0];
        target     = {target_int, {FRAC_BITS{1'b0}}};
        diff       = $signed({1'b0, target}) - $signed({1'b0, smoothed_reg});

        // A coefficient of one or more lands exactly on the target; below
        // that the fraction bits alone drive the multiplier.
        coef_full  = (smooth_coef_reg >= COEF_ONE);
        prod       = $signed({1'b0, smooth_coef_reg[FRAC_BITS-1:0]}) * diff;
        // Round half up, then floor by dropping the fraction bits.
        rounded    = prod + $signed(PW'(ROUND_HALF));
        step       = rounded[PW-1:FRAC_BITS];
        sum        = $signed({2'b00, smoothed_reg}) + step;

        smoothed_next = coef_full ? target : sum[SD_W-1:0];
    end

    // Stage B registers.
    logic                   b_valid_reg;
    logic [DEPTH_LOG2-1:0]  b_wp_reg;
    logic [SAMPLE_BITS-1:0] b_sample_reg;
    logic [DEPTH_LOG2-1:0]  b_dint_reg;
    logic                   b_wrapped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_coef_reg <= COEF_RESET;
            smoothed_reg    <= SD_RESET;
            wp_reg          <= '0;
            wrapped_reg     <= 1'b0;
            b_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                smooth_coef_reg <= cfg_wdata;
            end
            b_valid_reg <= s_fire;
            if (s_fire)
            begin
                smoothed_reg <= smoothed_next;
                wp_reg       <= wp_reg + 1'b1;
                if (wp_reg == WP_LAST)
                begin
                    wrapped_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            b_wp_reg      <= wp_reg;
            b_sample_reg  <= sample_ext[SAMPLE_BITS-1:0];
            b_dint_reg    <= smoothed_next[SD_W-1:FRAC_BITS];
            b_wrapped_reg <= wrapped_reg | (wp_reg == WP_LAST);
        end
    end

    // ------------------------------------------------------------------
    // Stage B: write the sample and read the delayed entry in the same cycle.
    // ------------------------------------------------------------------
    logic [DEPTH_LOG2-1:0]  b_wp_new;
    logic [DEPTH_LOG2-1:0]  b_rd_addr;
    logic                   b_hit;
    logic                   b_written;
    logic [SAMPLE_BITS-1:0] store_q;

    always_comb
    begin
        b_wp_new  = b_wp_reg + 1'b1;
        b_rd_addr = b_wp_new - b_dint_reg;
        // A delay of one reads the entry written in this same cycle; the
        // store returns old data then, so the sample is forwarded instead.
        b_hit     = (b_rd_addr == b_wp_reg);
        // Before the first wrap, entries at or above the new pointer have
        // never been written and stand for the cleared store.
        b_written = b_wrapped_reg | (b_rd_addr < b_wp_new);
    end

    svdl_store #(
        .ADDR_W (DEPTH_LOG2),
        .DATA_W (SAMPLE_BITS)
    ) u_store (
        .clk     (clk),
        .wr_en   (b_valid_reg),
        .wr_addr (b_wp_reg),
        .wr_data (b_sample_reg),
        .rd_en   (b_valid_reg),
        .rd_addr (b_rd_addr),
        .rd_data (store_q)
    );

    // Stage C registers.
    logic                   c_valid_reg;
    logic                   c_hit_reg;
    logic                   c_zero_reg;
    logic [SAMPLE_BITS-1:0] c_fwd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_valid_reg)
        begin
            c_hit_reg  <= b_hit;
            c_zero_reg <= ~b_written;
            c_fwd_reg  <= b_sample_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: pick the result word and push it into the output queue.
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] c_word;
    logic [31:0]            c_word32;
    logic [OUT_TDATA_W-1:0] push_data;
    logic [OFIFO_ADDR_W:0]  fifo_count;
    logic [OFIFO_ADDR_W+1:0] occupancy;

    always_comb
    begin
        if (c_zero_reg)
        begin
            c_word = '0;
        end
        else if (c_hit_reg)
        begin
            c_word = c_fwd_reg;
        end
        else
        begin
            c_word = store_q;
        end
        c_word32  = 32'(c_word);
        push_data = c_word32[OUT_TDATA_W-1:0];
    end

    svdl_ofifo #(
        .DATA_W (OUT_TDATA_W),
        .ADDR_W (OFIFO_ADDR_W)
    ) u_ofifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (c_valid_reg),
        .push_data (push_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .count     (fifo_count)
    );

    // Every request in flight holds a queue slot in reserve, so s_tready
    // depends on registers only and never on m_tready.
    assign occupancy = {1'b0, fifo_count}
                     + (OFIFO_ADDR_W + 2)'(b_valid_reg)
                     + (OFIFO_ADDR_W + 2)'(c_valid_reg);
    assign s_tready  = (occupancy < (OFIFO_ADDR_W + 2)'(OFIFO_DEPTH));

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `SVDL_ASSERT_NEXT(a_wrap_sticky, wrapped_reg, wrapped_reg,
        "wrap flag cleared after the store filled")
    `SVDL_ASSERT_IMPL(a_fwd_written, b_valid_reg && b_hit, b_written,
        "forwarded entry marked as never written")
    `SVDL_ASSERT_IMPL(a_queue_room, c_valid_reg && !(m_tvalid && m_tready),
        fifo_count != (OFIFO_ADDR_W + 1)'(OFIFO_DEPTH),
        "result pushed into a full output queue")

endmodule

### bench/delay_line_checker.sv
// Checker that predicts every delayed sample of the delay line and compares it with the output.
`timescale 1ns / 1ps

module delay_line_checker
    import svdl_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wen,
    input  logic [COEF_W-1:0]      cfg_wdata,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    output int unsigned            pending_results,
    output int unsigned            failures
);

    localparam int ADDR_W      = DEPTH_LOG2_DEF;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int DELAY_W     = ADDR_W + FRAC_BITS;
    localparam logic [ADDR_W-1:0] MAX_DELAY = {ADDR_W{1'b1}};
    localparam longint RESET_SAMPLES =
        (RESET_DELAY > STORE_DEPTH - 1) ? STORE_DEPTH - 1 : RESET_DELAY;
    localparam logic [DELAY_W-1:0] GLIDE_RESET = DELAY_W'(RESET_SAMPLES << FRAC_BITS);
    localparam int SHOWN_FAILURES = 10;

    // Predicted state of the block.
    logic [SAMPLE_W-1:0] history [STORE_DEPTH];
    logic [ADDR_W-1:0]   wr_ptr;
    logic [DELAY_W-1:0]  glide_delay;
    logic [COEF_W-1:0]   coef;

    logic [SAMPLE_W-1:0] expected_samples [$];
    int unsigned         fail_count;

    // Stores one sample, glides the delay one step toward the request and
    // returns the sample found at the new delay.
    function automatic logic [SAMPLE_W-1:0] glide_and_read(
        input logic [SAMPLE_W-1:0] sample,
        input logic [REQ_W-1:0]    request
    );
        logic [ADDR_W-1:0] target;
        logic [COEF_W-1:0] step_coef;
        logic [ADDR_W-1:0] rd_ptr;
        longint            diff;
        longint            prod;
        target    = (request > MAX_DELAY) ? MAX_DELAY : request[ADDR_W-1:0];
        step_coef = (coef > COEF_ONE) ? COEF_ONE : coef;
        history[wr_ptr] = sample;
        wr_ptr = wr_ptr + 1'b1;
        diff = (longint'(target) <<< FRAC_BITS) - longint'(glide_delay);
        prod = longint'(step_coef) * diff + ROUND_HALF;
        // Arithmetic shift of a signed value is division rounded toward minus infinity.
        glide_delay = DELAY_W'(longint'(glide_delay) + (prod >>> FRAC_BITS));
        rd_ptr = wr_ptr - glide_delay[DELAY_W-1:FRAC_BITS];
        return history[rd_ptr];
    endfunction

    task automatic note_failure(input string text);
        fail_count++;
        if (fail_count <= SHOWN_FAILURES)
            $display("delay line check failed at %0t: %s", $time, text);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [SAMPLE_W-1:0] expected;
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
                history[i] = '0;
            wr_ptr      = '0;
            glide_delay = GLIDE_RESET;
            coef        = COEF_RESET;
            expected_samples.delete();
            fail_count  = 0;
            pending_results <= 0;
            failures        <= 0;
        end
        else
        begin
            if (cfg_wen)
                coef = cfg_wdata;
            // A result never leaves at the edge that takes its request, so the output
            // side is handled before this edge's request is predicted.
            if (m_tvalid && m_tready)
            begin
                if (expected_samples.size() == 0)
                begin
                    note_failure($sformatf("result %0d with no request outstanding",
                                           $signed(m_tdata[SAMPLE_W-1:0])));
                end
                else
                begin
                    expected = expected_samples.pop_front();
                    if (m_tdata[SAMPLE_W-1:0] !== expected)
                        note_failure($sformatf("sample_out expected %0d, got %0d",
                                               $signed(expected),
                                               $signed(m_tdata[SAMPLE_W-1:0])));
                end
            end
            if (s_tvalid && s_tready)
                expected_samples.push_back(glide_and_read(s_tdata[SAMPLE_W-1:0],
                                                          s_tdata[SAMPLE_W +: REQ_W]));
            pending_results <= expected_samples.size();
            failures        <= fail_count;
        end
    end

endmodule

### bench/tb_top.sv
// Testbench top for the smoothed variable delay line: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_top;
    import svdl_pkg::*;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 8;
    // The limit leaves a wide margin over the slowest correct run, which spends
    // most of its time in the phases with heavy idling and the long hold-off.
    localparam int CYCLE_LIMIT     = 50_000;
    // Waiting past the pipeline latency lets any stray result show up.
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_ITEMS     = 100;
    localparam logic [REQ_W-1:0] LONGEST_REQUEST = '1;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_wen   = 1'b0;
    logic [COEF_W-1:0]      cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int unsigned pending_results;
    int unsigned failures;
    int unsigned cycle_count  = 0;
    // The sender's idle share is only read by the stimulus process itself;
    // the receiver's stall share is read by another process, so it changes
    // by nonblocking assignment.
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    logic        rx_hold      = 1'b0;
    event        rx_hold_go;

    smoothed_variable_delay_line_core i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    delay_line_checker i_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wen         (cfg_wen),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .pending_results (pending_results),
        .failures        (failures)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver: stalls at random with the current share, and stalls throughout
    // while a long hold-off is running.
    always @(posedge clk)
    begin
        m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end

    // Long hold-off, counted here so the sender can keep offering requests
    // while the output side is blocked; the block's queue fills and it has
    // to drop s_tready.
    initial
    begin
        forever
        begin
            @(rx_hold_go);
            rx_hold <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
        end
    end

    // Offers one request, idling first at random, and returns at the edge
    // where it is taken. s_tvalid gets at most one assignment per edge.
    task automatic send_request(input logic [SAMPLE_W-1:0] sample,
                                input logic [REQ_W-1:0]    request);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - REQ_W - SAMPLE_W){1'b0}}, request, sample};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Waits until every result is back and the pipeline has emptied, so the
    // coefficient can be changed safely.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_coef(input logic [COEF_W-1:0] value);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        @(posedge clk);
    endtask

    // Most delays are short so that they land on samples written recently;
    // the rest covers the far end, zero and the whole request field.
    function automatic logic [REQ_W-1:0] pick_request();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 50)
            return REQ_W'($urandom_range(0, 40));
        else if (roll < 70)
            return REQ_W'($urandom_range(0, 2000));
        else if (roll < 80)
            return ($urandom_range(1) != 0) ? LONGEST_REQUEST : '0;
        else
            return REQ_W'($urandom);
    endfunction

    task automatic random_phase(input int count, input int unsigned tx_pct,
                                input int unsigned rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct <= rx_pct;
        repeat (count) send_request(SAMPLE_W'($urandom), pick_request());
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset coefficient: the delay glides slowly away from 10000 samples,
        // where nothing has been written yet, so every result is zero.
        send_request(16'h7FFF, '0);
        send_request(16'h8000, LONGEST_REQUEST);
        send_request(16'h0000, 17'd1);
        send_request(16'hFFFF, 17'h10000);
        send_request(16'h5555, 17'h15555);
        send_request(16'hAAAA, 17'h0AAAA);

        // Coefficient of one: the delay jumps to each request at once.
        // A delay of one returns the sample of the same request; a delay of
        // zero and the longest delay reach entries not written since reset.
        wait_for_drain();
        write_coef(COEF_ONE);
        send_request(16'h1234, 17'd1);
        send_request(16'h8001, 17'd1);
        send_request(16'h7FFE, 17'd2);
        send_request(16'h0001, 17'd5);
        send_request(16'hC000, '0);
        send_request(16'h4000, LONGEST_REQUEST);
        send_request(16'hFFFE, 17'd3);
        send_request(16'h00FF, 17'd9);

        // Coefficient above one must act exactly like one.
        wait_for_drain();
        write_coef('1);
        send_request(16'h0F0F, 17'd1);
        send_request(16'hF0F0, 17'd4);
        send_request(16'h3C3C, '0);
        send_request(16'hC3C3, 17'd7);

        // Coefficient of zero freezes the delay whatever is requested.
        wait_for_drain();
        write_coef('0);
        send_request(16'h1111, LONGEST_REQUEST);
        send_request(16'h2222, '0);
        send_request(16'h3333, 17'd2);

        wait_for_drain();
        write_coef(COEF_ONE);
        random_phase(PHASE_ITEMS, 0, 0);

        wait_for_drain();
        write_coef(COEF_W'($urandom_range(1, 65535)));
        random_phase(PHASE_ITEMS, 71, 0);

        wait_for_drain();
        write_coef(COEF_ONE);
        random_phase(PHASE_ITEMS, 0, 71);

        wait_for_drain();
        write_coef(COEF_W'($urandom_range(1, 2000)));
        random_phase(PHASE_ITEMS, 28, 28);

        // Back pressure: the receiver holds off for a long stretch while the
        // sender keeps streaming requests.
        wait_for_drain();
        write_coef(COEF_ONE);
        random_phase(20, 0, 0);
        -> rx_hold_go;
        random_phase(PHASE_ITEMS, 0, 0);

        wait_for_drain();
        write_coef(COEF_W'($urandom_range(65537, 131071)));
        random_phase(PHASE_ITEMS, 28, 28);

        wait_for_drain();
        if (failures == 0 && pending_results == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### smoothed_variable_delay_line_core.f
+incdir+hdl
hdl/svdl_pkg.sv
hdl/svdl_store.sv
hdl/svdl_ofifo.sv
hdl/smoothed_variable_delay_line_core.sv
bench/delay_line_checker.sv
bench/tb_top.sv
